@@ rtl/throttle_dc_link_supervisor_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the throttle / DC link supervisor
// Concurrent checks sampled on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef THROTTLE_DC_LINK_SUPERVISOR_ASSERT_SVH
`define THROTTLE_DC_LINK_SUPERVISOR_ASSERT_SVH

// same-cycle implication
`define TDLS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tdls check failed: same-cycle implication");

// next-cycle implication
`define TDLS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tdls check failed: next-cycle implication");

`endif

@@ rtl/tdls_pkg.sv @@
// ----------------------------------------------------------------------------
// tdls_pkg
// Widths, codes and constants of the throttle / DC link supervisor.
// ----------------------------------------------------------------------------
package tdls_pkg;

  localparam int ADC_W      = 12;
  localparam int PCT_W      = 8;
  localparam int BRAKE_W    = 7;
  localparam int LIMIT_W    = 10;
  localparam int SLIP_W     = 11;
  localparam int AMP_W      = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam int FRAC = 5;

  // full-scale amplitude, 100 percent with FRAC fraction bits
  localparam logic [AMP_W-1:0]   AMP_FULL = AMP_W'(100 << FRAC);
  localparam logic [BRAKE_W-1:0] PCT_MAX  = BRAKE_W'(100);

  // serial divider: 20-bit dividend, 12-bit divisor
  localparam int DIV_W     = 20;
  localparam int DEN_W     = 12;
  localparam int DIV_CNT_W = 5;

  localparam logic [1:0] MODE_OFF  = 2'd0;
  localparam logic [1:0] MODE_SLIP = 2'd1;

  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_FAULT = 2'd1;
  localparam logic [1:0] KIND_MODE  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_POT_LO     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POT_HI     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BRAKE_SPAN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LINK_LEVEL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SLIP_LIMIT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_AMP_FLOOR  = 3'd5;

endpackage

@@ rtl/throttle_dc_link_supervisor.sv @@
// ----------------------------------------------------------------------------
// throttle_dc_link_supervisor - processes one item at a time; a new item is taken
// only after the result of the last one is registered, so a stalled result channel
// adds its stall. Two or three 20-bit divisions per item share one bit-serial divider
// (1 bit/cycle): three for an in-range tick with unequal bounds, two for any other item.
// Sync reset: config to defaults, filters/mode/relays cleared, output empty.
// ----------------------------------------------------------------------------
module throttle_dc_link_supervisor import tdls_pkg::*; #(
  parameter int AVG_SHIFT = 5
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   kind,
  input  logic [ADC_W-1:0]             throttle_raw,
  input  logic [ADC_W-1:0]             link_raw,
  input  logic                         start_pressed,
  input  logic [1:0]                   mode_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   mode_now,
  output logic signed [PCT_W-1:0]      pot_percent,
  output logic signed [SLIP_W-1:0]     slip_target,
  output logic [AMP_W-1:0]             amp_target,
  output logic                         dc_switch_on,
  output logic                         precharge_on,
  output logic                         error_on,
  output logic                         throttle_bad,
  output logic                         pwm_init_pulse,
  output logic                         pwm_off_pulse
);

  localparam int FW = ADC_W + AVG_SHIFT + 1;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_FILT  = 10'b00_0000_0010,
    S_EVAL  = 10'b00_0000_0100,
    S_DPOT  = 10'b00_0000_1000,
    S_POT   = 10'b00_0001_0000,
    S_SLIP  = 10'b00_0010_0000,
    S_DSLIP = 10'b00_0100_0000,
    S_AMP   = 10'b00_1000_0000,
    S_DAMP  = 10'b01_0000_0000,
    S_DONE  = 10'b10_0000_0000
  } state_t;

  state_t state;

  // configuration
  logic [ADC_W-1:0]   r_pot_lo, r_pot_hi, r_level;
  logic [BRAKE_W-1:0] r_brake;
  logic [LIMIT_W-1:0] r_slip;
  logic [AMP_W-1:0]   r_amp;

  // captured item
  logic [1:0]       kind_q, modev_q;
  logic [ADC_W-1:0] thr_q, link_q;
  logic             start_q;

  // supervisor state
  logic [ADC_W-1:0]        thr_avg, link_avg;
  logic [1:0]              mode_reg;
  logic                    init_flag, switch_reg, precharge_reg, error_reg;
  logic signed [PCT_W-1:0] pot_hold;
  logic signed [SLIP_W-1:0] slip_reg;
  logic                    flag_bad, flag_init, flag_off;

  // serial divider
  logic [DIV_W-1:0]     div_num;
  logic [DEN_W-1:0]     div_rem, div_den;
  logic [DIV_CNT_W-1:0] div_cnt;

  // combinational
  logic [FW-1:0]        thr_acc, link_acc;
  logic [ADC_W-1:0]     thr_filt, link_filt;
  logic [BRAKE_W-1:0]   brk;
  logic [PCT_W-1:0]     brk_sum;
  logic [ADC_W-1:0]     span, thr_off;
  logic                 thr_bad, link_high;
  logic [DIV_W-1:0]     pot_num, slip_num, amp_num;
  logic [PCT_W-1:0]     mag8;
  logic [BRAKE_W-1:0]   pot_mag;
  logic [AMP_W-1:0]     amp_fl, amp_val;
  logic [DEN_W:0]       trial;
  logic                 div_ge;
  logic [DEN_W-1:0]     rem_step;
  logic [PCT_W:0]       pot_q;
  logic [SLIP_W-1:0]    slip_mag;
  logic [1:0]           ctl_mode;
  logic                 ctl_sw, ctl_pre, ctl_err, ctl_init, ctl_ip, ctl_op;
  logic                 out_free;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign out_free  = !out_valid || out_ready;

  always_comb begin
    // avg' = (new + avg*(2^s - 1)) >> s
    thr_acc   = (FW'(thr_avg) << AVG_SHIFT) - FW'(thr_avg) + FW'(thr_q);
    link_acc  = (FW'(link_avg) << AVG_SHIFT) - FW'(link_avg) + FW'(link_q);
    thr_filt  = thr_acc[AVG_SHIFT +: ADC_W];
    link_filt = link_acc[AVG_SHIFT +: ADC_W];

    brk       = (r_brake > PCT_MAX) ? PCT_MAX : r_brake;
    brk_sum   = PCT_W'(PCT_MAX) + PCT_W'(brk);
    span      = r_pot_hi - r_pot_lo;
    thr_off   = thr_avg - r_pot_lo;
    thr_bad   = (thr_avg < r_pot_lo) || (thr_avg > r_pot_hi);
    link_high = (link_avg > r_level);
    pot_num   = DIV_W'(brk_sum) * DIV_W'(thr_off);

    mag8      = pot_hold[PCT_W-1] ? PCT_W'(-pot_hold) : PCT_W'(pot_hold);
    pot_mag   = mag8[BRAKE_W-1:0];
    slip_num  = DIV_W'(r_slip) * DIV_W'(pot_mag);
    amp_fl    = (r_amp > AMP_FULL) ? AMP_FULL : r_amp;
    amp_num   = DIV_W'(AMP_FULL - amp_fl) * DIV_W'(pot_mag);

    // restoring step, one quotient bit per cycle
    trial     = {div_rem, div_num[DIV_W-1]};
    div_ge    = (trial >= {1'b0, div_den});
    rem_step  = div_ge ? DEN_W'(trial - {1'b0, div_den}) : trial[DEN_W-1:0];

    pot_q     = {1'b0, div_num[PCT_W-1:0]} - (PCT_W+1)'(brk);
    slip_mag  = {1'b0, div_num[LIMIT_W-1:0]};
    amp_val   = amp_fl + div_num[AMP_W-1:0];

    // tick control: start mode is mode_reg, untouched until this point
    ctl_mode = mode_reg;
    ctl_sw   = switch_reg;
    ctl_pre  = precharge_reg;
    ctl_err  = error_reg;
    ctl_init = init_flag;
    ctl_ip   = 1'b0;
    ctl_op   = 1'b0;
    if (thr_bad) ctl_mode = MODE_OFF;
    if (link_high) begin
      if (start_q) begin
        ctl_sw   = 1'b1;
        ctl_err  = 1'b0;
        ctl_pre  = 1'b0;
        ctl_mode = MODE_SLIP;
      end
    end else begin
      ctl_pre = 1'b1;
    end
    if (mode_reg == MODE_OFF) begin
      ctl_init = 1'b0;
      ctl_sw   = 1'b0;
      ctl_err  = 1'b1;
      ctl_op   = 1'b1;
    end else if (!init_flag) begin
      ctl_ip   = 1'b1;
      ctl_err  = 1'b0;
      ctl_init = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      r_pot_lo      <= '0;
      r_pot_hi      <= '1;
      r_brake       <= '0;
      r_level       <= '1;
      r_slip        <= LIMIT_W'(32);
      r_amp         <= '0;
      thr_avg       <= '0;
      link_avg      <= '0;
      mode_reg      <= MODE_OFF;
      init_flag     <= 1'b0;
      pot_hold      <= '0;
      switch_reg    <= 1'b0;
      precharge_reg <= 1'b0;
      error_reg     <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_POT_LO:     r_pot_lo <= cfg_data[ADC_W-1:0];
          REG_POT_HI:     r_pot_hi <= cfg_data[ADC_W-1:0];
          REG_BRAKE_SPAN: r_brake  <= cfg_data[BRAKE_W-1:0];
          REG_LINK_LEVEL: r_level  <= cfg_data[ADC_W-1:0];
          REG_SLIP_LIMIT: r_slip   <= cfg_data[LIMIT_W-1:0];
          REG_AMP_FLOOR:  r_amp    <= cfg_data[AMP_W-1:0];
          default: ;
        endcase
      end

      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            kind_q    <= kind;
            thr_q     <= throttle_raw;
            link_q    <= link_raw;
            start_q   <= start_pressed;
            modev_q   <= mode_value;
            flag_bad  <= 1'b0;
            flag_init <= 1'b0;
            flag_off  <= 1'b0;
            state     <= S_FILT;
          end
        end
        S_FILT: begin
          if (kind_q == KIND_TICK) begin
            thr_avg  <= thr_filt;
            link_avg <= link_filt;
            state    <= S_EVAL;
          end else begin
            if (kind_q == KIND_FAULT) begin
              mode_reg  <= MODE_OFF;
              error_reg <= 1'b1;
            end else if (kind_q == KIND_MODE) begin
              mode_reg <= modev_q;
            end
            state <= S_SLIP;
          end
        end
        S_EVAL: begin
          mode_reg      <= ctl_mode;
          switch_reg    <= ctl_sw;
          precharge_reg <= ctl_pre;
          error_reg     <= ctl_err;
          init_flag     <= ctl_init;
          flag_bad      <= thr_bad;
          flag_init     <= ctl_ip;
          flag_off      <= ctl_op;
          if (thr_bad) begin
            state <= S_SLIP;
          end else if (span == '0) begin
            // equal bounds: throttle sits on the bound, full scale
            pot_hold <= PCT_W'(PCT_MAX);
            state    <= S_SLIP;
          end else begin
            div_num <= pot_num;
            div_den <= span;
            div_rem <= '0;
            div_cnt <= DIV_CNT_W'(DIV_W - 1);
            state   <= S_DPOT;
          end
        end
        S_DPOT, S_DSLIP, S_DAMP: begin
          div_num <= {div_num[DIV_W-2:0], div_ge};
          div_rem <= rem_step;
          div_cnt <= div_cnt - 1'b1;
          if (div_cnt == '0) begin
            if (state == S_DPOT) begin
              state <= S_POT;
            end else if (state == S_DSLIP) begin
              state <= S_AMP;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_POT: begin
          pot_hold <= pot_q[PCT_W-1:0];
          state    <= S_SLIP;
        end
        S_SLIP: begin
          div_num <= slip_num;
          div_den <= DEN_W'(PCT_MAX);
          div_rem <= '0;
          div_cnt <= DIV_CNT_W'(DIV_W - 1);
          state   <= S_DSLIP;
        end
        S_AMP: begin
          slip_reg <= pot_hold[PCT_W-1] ? SLIP_W'(-slip_mag) : slip_mag;
          div_num  <= amp_num;
          div_den  <= DEN_W'(PCT_MAX);
          div_rem  <= '0;
          div_cnt  <= DIV_CNT_W'(DIV_W - 1);
          state    <= S_DAMP;
        end
        S_DONE: begin
          if (out_free) begin
            mode_now       <= mode_reg;
            pot_percent    <= pot_hold;
            slip_target    <= slip_reg;
            amp_target     <= amp_val;
            dc_switch_on   <= switch_reg;
            precharge_on   <= precharge_reg;
            error_on       <= error_reg;
            throttle_bad   <= flag_bad;
            pwm_init_pulse <= flag_init;
            pwm_off_pulse  <= flag_off;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/tdls_checker.sv @@
// ----------------------------------------------------------------------------
// tdls_checker
// Port-level checks on the supervisor result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "throttle_dc_link_supervisor_assert.svh"

module tdls_checker import tdls_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [1:0]               mode_now,
  input logic signed [PCT_W-1:0]  pot_percent,
  input logic [AMP_W-1:0]         amp_target,
  input logic                     dc_switch_on,
  input logic                     error_on,
  input logic                     pwm_init_pulse,
  input logic                     pwm_off_pulse
);

  // a stalled transfer keeps its payload
  `TDLS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(mode_now) && $stable(pot_percent) && $stable(amp_target))

  `TDLS_ASSERT_NOW(a_pulse_excl, out_valid, !(pwm_init_pulse && pwm_off_pulse))

  // PWM off tick opens the switch and flags error
  `TDLS_ASSERT_NOW(a_off_state, out_valid && pwm_off_pulse, error_on && !dc_switch_on)

  `TDLS_ASSERT_NOW(a_init_no_err, out_valid && pwm_init_pulse, !error_on)

  `TDLS_ASSERT_NOW(a_pot_range, out_valid, (pot_percent >= -8'sd100) && (pot_percent <= 8'sd100))

endmodule

bind throttle_dc_link_supervisor tdls_checker u_tdls_checker (.*);
